// File: design/lruc_pkg.sv
package lruc_pkg;

  localparam int ADDR_W = 32;
  localparam int STAMP_W = 31;

  localparam int DEF_NUM_SETS = 4096;
  localparam int DEF_NUM_WAYS = 4;
  localparam int DEF_LINE_OFS_W = 6;
  localparam int DEF_TAG_W = 14;

  localparam int IN_TDATA_W = 64;
  localparam int OUT_TDATA_W = 8;
  localparam int OUT_WAY_W = 2;

endpackage

// File: design/lruc_ram.sv
module lruc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: design/four_way_lru_cache_tag_lookup.sv
// result: the result beat is registered as the lookup state ends, which waits while
//   an earlier result beat is still held; no new beat is accepted until the set row
//   has been read and written back through the single tag/stamp memory
// reset: synchronous; a clearing pass writes every set row (NUM_SETS, 4096 by
//   default) to zero, with s_axis_tready low until it is done
module four_way_lru_cache_tag_lookup
  import lruc_pkg::*;
#(
  parameter int NUM_SETS = DEF_NUM_SETS,
  parameter int NUM_WAYS = DEF_NUM_WAYS,
  parameter int LINE_OFS_W = DEF_LINE_OFS_W,
  parameter int TAG_W = DEF_TAG_W
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // address [31:0], access_time [62:32], zero [63]
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // hit [0], way [2:1], evicted [3], zero [7:4]
  output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  localparam int SET_BITS = $clog2(NUM_SETS);
  localparam int SET_W = (SET_BITS > 0) ? SET_BITS : 1;
  localparam int WAY_W = $clog2(NUM_WAYS);
  localparam int TREE_N = 2 ** WAY_W;
  localparam int TAG_BASE = NUM_WAYS;
  localparam int STAMP_BASE = NUM_WAYS + NUM_WAYS * TAG_W;
  localparam int ROW_W = STAMP_BASE + NUM_WAYS * STAMP_W;

  typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_LOOK} state_t;

  state_t               state;
  logic [SET_W-1:0]     clr_cnt;
  logic [SET_W-1:0]     set_q;
  logic [TAG_W-1:0]     tag_q;
  logic [STAMP_W-1:0]   time_q;
  logic                 out_hit;
  logic [OUT_WAY_W-1:0] out_way;
  logic                 out_evicted;

  logic [ADDR_W-1:0]    in_address;
  logic [63:0]          addr_ext;
  logic [63:0]          set_shift;
  logic [63:0]          tag_shift;
  logic [SET_W-1:0]     set_raw;
  logic [SET_W-1:0]     in_set;
  logic [TAG_W-1:0]     in_tag;
  logic                 in_accept;
  logic                 look_done;

  logic                 ram_wr_en;
  logic [SET_W-1:0]     ram_wr_addr;
  logic [ROW_W-1:0]     ram_wr_data;
  logic [ROW_W-1:0]     row;
  logic [ROW_W-1:0]     row_new;

  logic [NUM_WAYS-1:0]  way_valid;
  logic [TAG_W-1:0]     way_tag [NUM_WAYS];
  logic [STAMP_W-1:0]   way_stamp [NUM_WAYS];
  logic [NUM_WAYS-1:0]  way_match;
  logic                 hit;
  logic                 has_free;
  logic [WAY_W-1:0]     hit_way;
  logic [WAY_W-1:0]     free_way;
  logic [WAY_W-1:0]     chosen;
  logic [STAMP_W-1:0]   node_stamp [2*TREE_N];
  logic [WAY_W-1:0]     node_idx [2*TREE_N];

  // address split, set index wraps when NUM_SETS is not a power of two
  assign in_address = s_axis_tdata[ADDR_W-1:0];
  assign addr_ext = 64'(in_address);
  assign set_shift = addr_ext >> LINE_OFS_W;
  assign tag_shift = addr_ext >> (LINE_OFS_W + SET_BITS);
  assign set_raw = (SET_BITS == 0) ? '0 : set_shift[SET_W-1:0];
  assign in_tag = tag_shift[TAG_W-1:0];

  always_comb begin
    if ({1'b0, set_raw} >= (SET_W + 1)'(NUM_SETS)) begin
      in_set = set_raw - SET_W'(NUM_SETS);
    end else begin
      in_set = set_raw;
    end
  end

  assign s_axis_tready = (state == ST_IDLE);
  assign in_accept = s_axis_tvalid && s_axis_tready;
  assign look_done = (state == ST_LOOK) && (!m_axis_tvalid || m_axis_tready);

  lruc_ram #(
    .WIDTH (ROW_W),
    .DEPTH (NUM_SETS),
    .ADDR_W(SET_W)
  ) u_row_ram (
    .clk    (clk),
    .wr_en  (ram_wr_en),
    .wr_addr(ram_wr_addr),
    .wr_data(ram_wr_data),
    .rd_en  (in_accept),
    .rd_addr(in_set),
    .rd_data(row)
  );

  // unpack the set row
  always_comb begin
    way_valid = row[NUM_WAYS-1:0];
    for (int w = 0; w < NUM_WAYS; w++) begin
      way_tag[w] = row[TAG_BASE + w*TAG_W +: TAG_W];
      way_stamp[w] = row[STAMP_BASE + w*STAMP_W +: STAMP_W];
      way_match[w] = way_valid[w] && (way_tag[w] == tag_q);
    end
  end

  // lowest matching way and lowest free way
  always_comb begin
    hit = 1'b0;
    has_free = 1'b0;
    hit_way = '0;
    free_way = '0;
    for (int w = NUM_WAYS - 1; w >= 0; w--) begin
      if (way_match[w]) begin
        hit = 1'b1;
        hit_way = WAY_W'(w);
      end
      if (!way_valid[w]) begin
        has_free = 1'b1;
        free_way = WAY_W'(w);
      end
    end
  end

  // oldest stamp tree, left side wins ties
  always_comb begin
    for (int i = 0; i < TREE_N; i++) begin
      node_idx[TREE_N + i] = WAY_W'(i);
      if (i < NUM_WAYS) begin
        node_stamp[TREE_N + i] = way_stamp[i];
      end else begin
        node_stamp[TREE_N + i] = '1;
      end
    end
    node_stamp[0] = '0;
    node_idx[0] = '0;
    for (int k = TREE_N - 1; k >= 1; k--) begin
      if (node_stamp[2*k + 1] < node_stamp[2*k]) begin
        node_stamp[k] = node_stamp[2*k + 1];
        node_idx[k] = node_idx[2*k + 1];
      end else begin
        node_stamp[k] = node_stamp[2*k];
        node_idx[k] = node_idx[2*k];
      end
    end
  end

  always_comb begin
    if (hit) begin
      chosen = hit_way;
    end else if (has_free) begin
      chosen = free_way;
    end else begin
      chosen = node_idx[1];
    end
  end

  always_comb begin
    row_new = row;
    for (int w = 0; w < NUM_WAYS; w++) begin
      if (chosen == WAY_W'(w)) begin
        row_new[w] = 1'b1;
        row_new[TAG_BASE + w*TAG_W +: TAG_W] = tag_q;
        row_new[STAMP_BASE + w*STAMP_W +: STAMP_W] = time_q;
      end
    end
  end

  always_comb begin
    if (state == ST_CLEAR) begin
      ram_wr_en = 1'b1;
      ram_wr_addr = clr_cnt;
      ram_wr_data = '0;
    end else begin
      ram_wr_en = look_done;
      ram_wr_addr = set_q;
      ram_wr_data = row_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      clr_cnt <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready && !look_done) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        ST_CLEAR: begin
          clr_cnt <= clr_cnt + SET_W'(1);
          if (clr_cnt == SET_W'(NUM_SETS - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_accept) begin
            set_q <= in_set;
            tag_q <= in_tag;
            time_q <= s_axis_tdata[ADDR_W +: STAMP_W];
            state <= ST_LOOK;
          end
        end
        ST_LOOK: begin
          if (look_done) begin
            m_axis_tvalid <= 1'b1;
            out_hit <= hit;
            out_way <= OUT_WAY_W'(chosen);
            out_evicted <= !hit && !has_free;
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tdata = {{(OUT_TDATA_W - OUT_WAY_W - 2){1'b0}}, out_evicted, out_way, out_hit};

`ifndef SYNTHESIS
  // one lookup in flight at a time
  assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted while a lookup is in flight");

  // every accepted beat reaches the lookup cycle
  assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> state == ST_LOOK)
    else $error("accepted beat did not start a lookup");

  // row write-back and result load go together
  assert property (@(posedge clk) disable iff (rst)
    ram_wr_en && state == ST_LOOK |=> m_axis_tvalid)
    else $error("row written back without a result beat");

  // a hit never reports an eviction
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !(m_axis_tdata[0] && m_axis_tdata[3]))
    else $error("hit and eviction reported together");
`endif

endmodule

// File: test/four_way_lru_cache_tag_lookup_checker.sv
module four_way_lru_cache_tag_lookup_checker
  import lruc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  input  logic                   s_axis_tready,
  // address [31:0], access_time [62:32], zero [63]
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  input  logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // hit [0], way [2:1], evicted [3], zero [7:4]
  input  logic [OUT_TDATA_W-1:0] m_axis_tdata,
  output int                     fail_count,
  output int                     pending
);

  localparam int LINES = DEF_NUM_SETS * DEF_NUM_WAYS;

  typedef struct packed {
    logic                 evicted;
    logic [OUT_WAY_W-1:0] way;
    logic                 hit;
  } lookup_t;

  bit                  line_valid [LINES];
  logic [13:0]         line_tag   [LINES];
  logic [STAMP_W-1:0]  line_stamp [LINES];
  lookup_t             lookup_q [$];

  function automatic lookup_t access_line(logic [ADDR_W-1:0] addr, logic [STAMP_W-1:0] now);
    int base;
    int pick;
    logic [13:0] tg;
    logic [STAMP_W-1:0] oldest;
    lookup_t r;
    bit found;
    base = int'(addr[17:6]) * DEF_NUM_WAYS;
    tg = addr[31:18];
    r = '0;
    pick = 0;
    found = 0;
    for (int w = 0; w < DEF_NUM_WAYS; w++) begin
      if (!found && line_valid[base + w] && line_tag[base + w] == tg) begin
        found = 1;
        pick = w;
      end
    end
    r.hit = found;
    if (!found) begin
      for (int w = 0; w < DEF_NUM_WAYS; w++) begin
        if (!found && !line_valid[base + w]) begin
          found = 1;
          pick = w;
        end
      end
      if (!found) begin
        // all ways valid: oldest stamp loses, lowest way on ties
        oldest = line_stamp[base];
        pick = 0;
        for (int w = 1; w < DEF_NUM_WAYS; w++) begin
          if (line_stamp[base + w] < oldest) begin
            oldest = line_stamp[base + w];
            pick = w;
          end
        end
        r.evicted = 1'b1;
      end
      line_valid[base + pick] = 1'b1;
      line_tag[base + pick] = tg;
    end
    line_stamp[base + pick] = now;
    r.way = pick[OUT_WAY_W-1:0];
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    $display("t=%0t bad result beat: %s", $realtime, msg);
    fail_count++;
  endtask

  always @(posedge clk) begin
    lookup_t got;
    lookup_t want;
    if (rst) begin
      for (int i = 0; i < LINES; i++) line_valid[i] = 1'b0;
      lookup_q.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[3:0];
        if (lookup_q.size() == 0) begin
          report_mismatch($sformatf("unexpected beat %h", m_axis_tdata));
        end else begin
          want = lookup_q.pop_front();
          if (got.hit !== want.hit)
            report_mismatch($sformatf("hit %b, want %b", got.hit, want.hit));
          if (got.way !== want.way)
            report_mismatch($sformatf("way %0d, want %0d", got.way, want.way));
          if (got.evicted !== want.evicted)
            report_mismatch($sformatf("evicted %b, want %b", got.evicted, want.evicted));
          if (m_axis_tdata[7:4] !== 4'b0)
            report_mismatch($sformatf("pad bits %b", m_axis_tdata[7:4]));
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        lookup_q.push_back(access_line(s_axis_tdata[31:0], s_axis_tdata[62:32]));
    end
    pending = lookup_q.size();
  end

endmodule

// File: test/four_way_lru_cache_tag_lookup_tb.sv
module four_way_lru_cache_tag_lookup_tb;
  import lruc_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam int RANDOM_ITEMS = 400;

  typedef enum int {RX_FREE, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  int fail_count;
  int pending;
  int cycle_count = 0;
  int sent_count = 0;
  int burst_left = 0;

  rx_mode_t rx_mode = RX_FREE;
  int rx_left = 0;
  int hold_left = 0;
  bit hold_done = 0;

  logic [STAMP_W-1:0] now_stamp = '0;
  logic [11:0] hot_sets [6];
  logic [13:0] hot_tags [6];

  always #5 clk = ~clk;

  four_way_lru_cache_tag_lookup dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  four_way_lru_cache_tag_lookup_checker lookup_check (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .fail_count    (fail_count),
    .pending       (pending)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // receiver: one long hold-off once traffic is flowing, otherwise shifting stall patterns
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (!hold_done && sent_count >= 150) begin
      hold_done = 1;
      hold_left = 399;
      m_axis_tready <= 1'b0;
    end else begin
      if (rx_left == 0) begin
        rx_mode = rx_mode_t'($urandom_range(0, 3));
        rx_left = $urandom_range(8, 80);
      end
      rx_left--;
      case (rx_mode)
        RX_FREE:   m_axis_tready <= 1'b1;
        RX_COIN:   m_axis_tready <= 1'($urandom_range(0, 1));
        RX_SPARSE: m_axis_tready <= ($urandom_range(0, 3) == 0);
        default:   m_axis_tready <= (cycle_count % 5 != 0);
      endcase
    end
  end

  function automatic logic [ADDR_W-1:0] line_addr(logic [13:0] tg, logic [11:0] set_idx,
                                                  logic [5:0] off);
    return {tg, set_idx, off};
  endfunction

  task automatic send_beat(logic [ADDR_W-1:0] addr, logic [STAMP_W-1:0] stamp);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {1'b0, stamp, addr};
    do @(posedge clk); while (!s_axis_tready);
    sent_count++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 8);
    end
  endtask

  task automatic refill_pools;
    for (int i = 0; i < 6; i++) begin
      hot_sets[i] = 12'($urandom());
      hot_tags[i] = 14'($urandom());
    end
  endtask

  initial begin
    logic [ADDR_W-1:0] addr;
    logic [STAMP_W-1:0] stamp;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // set 0: fill, hit, evict oldest, tie goes to lowest way, stamp going backward
    send_beat(line_addr(14'd0, 12'd0, 6'd0), 31'd0);
    send_beat(32'hFFFF_FFFF, 31'h7FFF_FFFF);
    send_beat(line_addr(14'd0, 12'd0, 6'd63), 31'd5);
    send_beat(line_addr(14'd1, 12'd0, 6'd1), 31'd10);
    send_beat(line_addr(14'd2, 12'd0, 6'd2), 31'd10);
    send_beat(line_addr(14'd3, 12'd0, 6'd3), 31'd10);
    send_beat(line_addr(14'd4, 12'd0, 6'd4), 31'd20);
    send_beat(line_addr(14'd5, 12'd0, 6'd5), 31'd20);
    send_beat(line_addr(14'd2, 12'd0, 6'd6), 31'd1);
    send_beat(line_addr(14'd6, 12'd0, 6'd7), 31'd30);
    // top set: all stamps at maximum, then a zero stamp
    send_beat(line_addr(14'd0, 12'hFFF, 6'd0), 31'h7FFF_FFFF);
    send_beat(line_addr(14'd1, 12'hFFF, 6'd0), 31'h7FFF_FFFF);
    send_beat(line_addr(14'd2, 12'hFFF, 6'd0), 31'h7FFF_FFFF);
    send_beat(line_addr(14'd3, 12'hFFF, 6'd0), 31'd0);
    send_beat(line_addr(14'h3FFF, 12'hFFF, 6'd0), 31'h7FFF_FFFF);
    send_beat(line_addr(14'd1, 12'hFFF, 6'd63), 31'd0);
    // alternating bit patterns
    send_beat(32'hAAAA_AAAA, 31'h2AAA_AAAA);
    send_beat(32'h5555_5555, 31'h5555_5555);
    send_beat(32'hAAAA_AAAA, 31'h5555_5555);
    send_beat(32'h5555_5555, 31'h2AAA_AAAA);

    now_stamp = 31'd100;
    refill_pools();
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 100 == 99) refill_pools();
      if ($urandom_range(0, 99) < 85) begin
        addr = line_addr(hot_tags[$urandom_range(0, 5)], hot_sets[$urandom_range(0, 5)],
                         6'($urandom()));
      end else begin
        addr = $urandom();
      end
      if ($urandom_range(0, 9) == 0) begin
        stamp = STAMP_W'($urandom());
      end else begin
        now_stamp = now_stamp + STAMP_W'($urandom_range(0, 3));
        stamp = now_stamp;
      end
      send_beat(addr, stamp);
    end

    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
